### design/cfl_pkg.sv
// ----------------------------------------------------------------------------
// cfl_pkg
// shared types and constants of the command fifo with latency statistics
// ----------------------------------------------------------------------------
package cfl_pkg;

  localparam int TYPE_W  = 8;
  localparam int ARG_W   = 32;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 64;

  // divider: two quotient bits per cycle over the whole dividend
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_STEPS          = SUM_W / DIV_BITS_PER_CYCLE;

  // item kind codes
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_EMIT
  } cfl_state_t;

  // one fifo entry as stored in the ram
  typedef struct packed {
    logic [TYPE_W-1:0] cmd_type;
    logic [ARG_W-1:0]  arg0;
    logic [ARG_W-1:0]  arg1;
    logic [TIME_W-1:0] stamp;
  } cfl_entry_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } cfl_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CNT_W-1:0] quotient;
  } cfl_div_rsp_t;

endpackage

### design/command_fifo_latency_stats.sv
// ----------------------------------------------------------------------------
// command_fifo_latency_stats
// circular command fifo with time stamps and dequeue latency statistics
// ----------------------------------------------------------------------------
//
//  channel  handshake           payload
//  -------  ------------------  -------------------------------------------
//  in       in_valid/in_stall   kind, now_ms, cmd_type, cmd_arg0, cmd_arg1
//  out      out_valid/out_stall ok, type, args, fill, latency stats, counters
//
//  one item at a time; enqueue or empty dequeue: accept, then the emit state
//  loads the output register
//  dequeue with an entry: accept with ram read, pop, mean divider (2 bits a
//  cycle over the 64-bit sum), divider done, output load
//  rst_n (synchronous) clears pointers, fill, statistics and counters; the
//  entry ram holds no reset and needs no clearing pass
//  the result sits in its own output register, so the next input transfer
//  is taken while the previous result is still stalled; a finished item
//  waits in the emit state only if that register is still occupied
//
module command_fifo_latency_stats #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [cfl_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [cfl_pkg::TYPE_W-1:0]        in_cmd_type,
  input  logic [cfl_pkg::ARG_W-1:0]         in_cmd_arg0,
  input  logic [cfl_pkg::ARG_W-1:0]         in_cmd_arg1,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_ok,
  output logic [cfl_pkg::TYPE_W-1:0]        out_type,
  output logic [cfl_pkg::ARG_W-1:0]         out_arg0,
  output logic [cfl_pkg::ARG_W-1:0]         out_arg1,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]   out_fill_level,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]   out_peak_fill,
  output logic [cfl_pkg::TIME_W-1:0]        out_latency_last,
  output logic [cfl_pkg::TIME_W-1:0]        out_latency_peak,
  output logic [cfl_pkg::TIME_W-1:0]        out_latency_mean,
  output logic [cfl_pkg::CNT_W-1:0]         out_full_drops,
  output logic [cfl_pkg::CNT_W-1:0]         out_enqueue_total,
  output logic [cfl_pkg::CNT_W-1:0]         out_dequeue_total
);
  import cfl_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

  cfl_state_t state_r, state_nxt;

  // fifo control state
  logic [PTR_W-1:0]  rd_ptr_r, wr_ptr_r;
  logic [OCC_W-1:0]  occ_r, occ_peak_r;

  // statistics
  logic [TIME_W-1:0] lat_last_r, lat_peak_r, lat_mean_r;
  logic [SUM_W-1:0]  lat_sum_r;
  logic [CNT_W-1:0]  samples_r, drops_r, pushes_r, pops_r;

  // current item and its result fields
  logic [TIME_W-1:0] now_r;
  logic              res_ok_r;
  logic [TYPE_W-1:0] res_type_r;
  logic [ARG_W-1:0]  res_arg0_r, res_arg1_r;

  // output register
  logic              out_valid_r;

  // control strobes
  logic              accept, full, empty;
  logic              do_enq, do_drop, do_deq_rd, do_deq_empty;
  logic              do_pop, load_out;

  // ram signals
  cfl_entry_t        wr_entry, rd_entry;
  logic [$bits(cfl_entry_t)-1:0] ram_rdata;

  // pop datapath
  logic [TIME_W-1:0] lat;
  logic [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  samples_nxt;

  cfl_div_req_t      div_req;
  cfl_div_rsp_t      div_rsp;

  assign full  = (occ_r == OCC_W'(FIFO_DEPTH));
  assign empty = (occ_r == '0);

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign do_enq       = accept && (in_kind == KIND_ENQ) && !full;
  assign do_drop      = accept && (in_kind == KIND_ENQ) && full;
  assign do_deq_rd    = accept && (in_kind == KIND_DEQ) && !empty;
  assign do_deq_empty = accept && (in_kind == KIND_DEQ) && empty;
  assign do_pop       = (state_r == ST_READ);
  assign load_out     = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = do_deq_rd ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        // a wrapped sample count leaves the mean alone
        state_nxt = (samples_nxt != '0) ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // entry ram: written on enqueue, read at the head on dequeue
  assign wr_entry.cmd_type = in_cmd_type;
  assign wr_entry.arg0     = in_cmd_arg0;
  assign wr_entry.arg1     = in_cmd_arg1;
  assign wr_entry.stamp    = in_now_ms;

  cfl_ram #(
    .WIDTH ($bits(cfl_entry_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (do_enq),
    .waddr (wr_ptr_r),
    .wdata (wr_entry),
    .re    (do_deq_rd),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign rd_entry = cfl_entry_t'(ram_rdata);

  // wrap-safe latency and new running sum
  assign lat         = now_r - rd_entry.stamp;
  assign sum_nxt     = lat_sum_r + SUM_W'(lat);
  assign samples_nxt = samples_r + 1'b1;

  assign div_req.start    = do_pop && (samples_nxt != '0);
  assign div_req.dividend = sum_nxt;
  assign div_req.divisor  = samples_nxt;

  cfl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // fifo pointers, fill and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      occ_r      <= '0;
      occ_peak_r <= '0;
      lat_last_r <= '0;
      lat_peak_r <= '0;
      lat_mean_r <= '0;
      lat_sum_r  <= '0;
      samples_r  <= '0;
      drops_r    <= '0;
      pushes_r   <= '0;
      pops_r     <= '0;
    end else begin
      if (do_enq) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
        occ_r    <= occ_r + 1'b1;
        pushes_r <= pushes_r + 1'b1;
        if ((occ_r + 1'b1) > occ_peak_r) begin
          occ_peak_r <= occ_r + 1'b1;
        end
      end
      if (do_drop) begin
        drops_r <= drops_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r   <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
        occ_r      <= occ_r - 1'b1;
        pops_r     <= pops_r + 1'b1;
        lat_last_r <= lat;
        if (lat > lat_peak_r) begin
          lat_peak_r <= lat;
        end
        lat_sum_r  <= sum_nxt;
        samples_r  <= samples_nxt;
      end
      if ((state_r == ST_DIV) && div_rsp.done) begin
        lat_mean_r <= div_rsp.quotient;
      end
    end
  end

  // item time stamp and per-item result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r      <= in_now_ms;
      res_ok_r   <= do_enq;
      res_type_r <= '0;
      res_arg0_r <= '0;
      res_arg1_r <= '0;
    end
    if (do_pop) begin
      res_ok_r   <= 1'b1;
      res_type_r <= rd_entry.cmd_type;
      res_arg0_r <= rd_entry.arg0;
      res_arg1_r <= rd_entry.arg1;
    end
  end

  // output register: a full snapshot so later items cannot disturb it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ok            <= res_ok_r;
      out_type          <= res_type_r;
      out_arg0          <= res_arg0_r;
      out_arg1          <= res_arg1_r;
      out_fill_level    <= occ_r;
      out_peak_fill     <= occ_peak_r;
      out_latency_last  <= lat_last_r;
      out_latency_peak  <= lat_peak_r;
      out_latency_mean  <= lat_mean_r;
      out_full_drops    <= drops_r;
      out_enqueue_total <= pushes_r;
      out_dequeue_total <= pops_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### design/cfl_ram.sv
// ----------------------------------------------------------------------------
// cfl_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/cfl_div.sv
// ----------------------------------------------------------------------------
// cfl_div
// restoring 64 by 32 unsigned divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module cfl_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfl_pkg::cfl_div_req_t req,
  output cfl_pkg::cfl_div_rsp_t rsp
);
  import cfl_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvsr_r;
  logic [SUM_W-1:0]  shreg_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [CNT_W:0]    r1, r2;
  logic              q1, q2;
  logic [CNT_W-1:0]  rem1, rem2;

  // two dependent restoring steps
  always_comb begin
    r1   = {rem_r, shreg_r[SUM_W-1]};
    q1   = (r1 >= {1'b0, dvsr_r});
    rem1 = q1 ? CNT_W'(r1 - {1'b0, dvsr_r}) : r1[CNT_W-1:0];
    r2   = {rem1, shreg_r[SUM_W-2]};
    q2   = (r2 >= {1'b0, dvsr_r});
    rem2 = q2 ? CNT_W'(r2 - {1'b0, dvsr_r}) : r2[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r   <= '0;
      dvsr_r  <= req.divisor;
      shreg_r <= req.dividend;
    end else if (busy_r) begin
      rem_r   <= rem2;
      shreg_r <= {shreg_r[SUM_W-3:0], q1, q2};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = shreg_r[CNT_W-1:0];

endmodule

### dv/tb_command_fifo_latency_stats.sv
// ----------------------------------------------------------------------------
// tb_command_fifo_latency_stats
// self-checking bench for the command fifo with dequeue latency statistics
// a clocked driver feeds enqueue and dequeue commands from a pending queue
// a shadow fifo computes each expected status record as a command transfers
// a clocked monitor compares every result transfer, field by field
// both sides insert random idle cycles
// ----------------------------------------------------------------------------
module tb_command_fifo_latency_stats;
  timeunit 1ns;
  timeprecision 1ps;

  import cfl_pkg::*;

  localparam int DEPTH        = 16;
  localparam int FILL_W       = $clog2(DEPTH + 1);
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int RANDOM_CMDS  = 750;
  localparam int MAX_WAIT     = 13;
  // room for a whole dequeue, plus a full gap and a full stall
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] now_ms;
    logic [TYPE_W-1:0] cmd_type;
    logic [ARG_W-1:0]  arg0;
    logic [ARG_W-1:0]  arg1;
  } fifo_cmd_t;

  typedef struct packed {
    logic              ok;
    logic [TYPE_W-1:0] cmd_type;
    logic [ARG_W-1:0]  arg0;
    logic [ARG_W-1:0]  arg1;
    logic [FILL_W-1:0] fill;
    logic [FILL_W-1:0] peak_fill;
    logic [TIME_W-1:0] lat_last;
    logic [TIME_W-1:0] lat_peak;
    logic [TIME_W-1:0] lat_mean;
    logic [CNT_W-1:0]  drops;
    logic [CNT_W-1:0]  pushes;
    logic [CNT_W-1:0]  pops;
  } fifo_status_t;

  // shapes of the random command runs
  typedef enum int {FILL_RUN, DRAIN_RUN, MIXED_RUN} run_shape_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic              in_kind     = KIND_ENQ;
  logic [TIME_W-1:0] in_now_ms   = '0;
  logic [TYPE_W-1:0] in_cmd_type = '0;
  logic [ARG_W-1:0]  in_cmd_arg0 = '0;
  logic [ARG_W-1:0]  in_cmd_arg1 = '0;

  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic              out_ok;
  logic [TYPE_W-1:0] out_type;
  logic [ARG_W-1:0]  out_arg0;
  logic [ARG_W-1:0]  out_arg1;
  logic [FILL_W-1:0] out_fill_level;
  logic [FILL_W-1:0] out_peak_fill;
  logic [TIME_W-1:0] out_latency_last;
  logic [TIME_W-1:0] out_latency_peak;
  logic [TIME_W-1:0] out_latency_mean;
  logic [CNT_W-1:0]  out_full_drops;
  logic [CNT_W-1:0]  out_enqueue_total;
  logic [CNT_W-1:0]  out_dequeue_total;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  command_fifo_latency_stats #(
    .FIFO_DEPTH(DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_now_ms        (in_now_ms),
    .in_cmd_type      (in_cmd_type),
    .in_cmd_arg0      (in_cmd_arg0),
    .in_cmd_arg1      (in_cmd_arg1),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_type         (out_type),
    .out_arg0         (out_arg0),
    .out_arg1         (out_arg1),
    .out_fill_level   (out_fill_level),
    .out_peak_fill    (out_peak_fill),
    .out_latency_last (out_latency_last),
    .out_latency_peak (out_latency_peak),
    .out_latency_mean (out_latency_mean),
    .out_full_drops   (out_full_drops),
    .out_enqueue_total(out_enqueue_total),
    .out_dequeue_total(out_dequeue_total)
  );

  // ---------------------------------------------------------------------------
  // shadow fifo and statistics, state after reset
  // ---------------------------------------------------------------------------
  cfl_entry_t        ring [DEPTH];
  logic [PTR_W-1:0]  head_idx    = '0;
  logic [PTR_W-1:0]  tail_idx    = '0;
  logic [FILL_W-1:0] held        = '0;
  logic [FILL_W-1:0] held_peak   = '0;
  logic [TIME_W-1:0] lat_last    = '0;
  logic [TIME_W-1:0] lat_peak    = '0;
  logic [TIME_W-1:0] lat_mean    = '0;
  logic [SUM_W-1:0]  lat_sum     = '0;
  logic [CNT_W-1:0]  lat_samples = '0;
  logic [CNT_W-1:0]  drop_cnt    = '0;
  logic [CNT_W-1:0]  push_cnt    = '0;
  logic [CNT_W-1:0]  pop_cnt     = '0;
  int                empty_pops  = 0;

  fifo_cmd_t    pending_cmds [$];
  fifo_status_t results_due  [$];

  int err_count     = 0;
  int in_transfers  = 0;
  int out_transfers = 0;

  // applies one command to the shadow fifo and returns the status it reports
  function automatic fifo_status_t apply_command(fifo_cmd_t c);
    fifo_status_t r;
    cfl_entry_t   e;
    logic [TIME_W-1:0] lat;
    r = '0;
    if (c.kind == KIND_ENQ) begin
      if (held == DEPTH) begin
        // full: nothing stored, only the drop counter moves
        drop_cnt = drop_cnt + 1'b1;
      end else begin
        ring[tail_idx] = '{cmd_type: c.cmd_type, arg0: c.arg0, arg1: c.arg1,
                           stamp: c.now_ms};
        tail_idx = tail_idx + 1'b1;   // depth is a power of two
        held     = held + 1'b1;
        push_cnt = push_cnt + 1'b1;
        if (held > held_peak) held_peak = held;
        r.ok = 1'b1;
      end
    end else if (held != 0) begin
      e   = ring[head_idx];
      lat = c.now_ms - e.stamp;       // wrap-safe modulo 2^32
      r.ok       = 1'b1;
      r.cmd_type = e.cmd_type;
      r.arg0     = e.arg0;
      r.arg1     = e.arg1;
      head_idx   = head_idx + 1'b1;
      held       = held - 1'b1;
      pop_cnt    = pop_cnt + 1'b1;
      lat_last   = lat;
      if (lat > lat_peak) lat_peak = lat;
      lat_sum     = lat_sum + SUM_W'(lat);
      lat_samples = lat_samples + 1'b1;
      // a wrapped sample count leaves the mean as it was
      if (lat_samples != 0) lat_mean = TIME_W'(lat_sum / SUM_W'(lat_samples));
    end else begin
      empty_pops++;
    end
    r.fill      = held;
    r.peak_fill = held_peak;
    r.lat_last  = lat_last;
    r.lat_peak  = lat_peak;
    r.lat_mean  = lat_mean;
    r.drops     = drop_cnt;
    r.pushes    = push_cnt;
    r.pops      = pop_cnt;
    return r;
  endfunction

  function automatic int draw_wait(bit no_idle);
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic push_cmd(logic kind, logic [TIME_W-1:0] now_ms, logic [TYPE_W-1:0] typ,
                          logic [ARG_W-1:0] a0, logic [ARG_W-1:0] a1);
    fifo_cmd_t c;
    c = '{kind: kind, now_ms: now_ms, cmd_type: typ, arg0: a0, arg1: a1};
    pending_cmds.push_back(c);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one command held on the input ports until it transfers
  // ---------------------------------------------------------------------------
  fifo_cmd_t in_flight;
  int        in_wait    = 0;
  bit        in_no_idle = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // predict at the transfer, from the payload the block saw
      if (in_valid && !in_stall) begin
        results_due.push_back(apply_command(in_flight));
        in_transfers++;
      end
      if (!in_valid || !in_stall) begin
        if (in_wait != 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          in_flight = pending_cmds.pop_front();
          in_valid    <= 1'b1;
          in_kind     <= in_flight.kind;
          in_now_ms   <= in_flight.now_ms;
          in_cmd_type <= in_flight.cmd_type;
          in_cmd_arg0 <= in_flight.arg0;
          in_cmd_arg1 <= in_flight.arg1;
          // gap before the next command; sometimes a run with no gaps at all
          in_wait = draw_wait(in_no_idle);
          if ($urandom_range(0, 39) == 0) in_no_idle = !in_no_idle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall, compare each result transfer with the oldest one due
  // ---------------------------------------------------------------------------
  int out_hold    = 0;
  bit out_no_idle = 1'b0;

  always @(posedge clk) begin
    fifo_status_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_transfers++;
        if (results_due.size() == 0) begin
          $display("%0t: result transfer with none due, expected nothing, actual ok=%0b fill=%0d",
                   $time, out_ok, out_fill_level);
          err_count++;
        end else begin
          want = results_due.pop_front();
          compare_field("ok",            want.ok,        out_ok);
          compare_field("out_type",      want.cmd_type,  out_type);
          compare_field("out_arg0",      want.arg0,      out_arg0);
          compare_field("out_arg1",      want.arg1,      out_arg1);
          compare_field("fill_level",    want.fill,      out_fill_level);
          compare_field("peak_fill",     want.peak_fill, out_peak_fill);
          compare_field("latency_last",  want.lat_last,  out_latency_last);
          compare_field("latency_peak",  want.lat_peak,  out_latency_peak);
          compare_field("latency_mean",  want.lat_mean,  out_latency_mean);
          compare_field("full_drops",    want.drops,     out_full_drops);
          compare_field("enqueue_total", want.pushes,    out_enqueue_total);
          compare_field("dequeue_total", want.pops,      out_dequeue_total);
        end
        out_hold = draw_wait(out_no_idle);
        if ($urandom_range(0, 39) == 0) out_no_idle = !out_no_idle;
      end else if (out_hold != 0) begin
        out_hold--;
      end
      // the stall count runs whether or not a result is waiting
      out_stall <= (out_hold != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transfer on either side
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still due",
                 $time, idle_cycles, results_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [TIME_W-1:0] t_ms;
    logic              kind;
    run_shape_t        shape;
    int                run_left;
    int                pick;

    // directed: empty dequeue, field extremes, latency wrap
    push_cmd(KIND_DEQ, 32'd0, 8'hff, '1, '1);
    push_cmd(KIND_ENQ, 32'd0, 8'h00, '0, '0);
    push_cmd(KIND_ENQ, 32'hffff_ffff, 8'hff, '1, '1);
    push_cmd(KIND_DEQ, 32'd5, 8'h00, '0, '0);
    // stamp is all ones, so the latency wraps through zero
    push_cmd(KIND_DEQ, 32'd3, 8'ha5, 32'h5a5a_5a5a, 32'ha5a5_a5a5);
    // fill to the top, then two drops on a full fifo
    for (int i = 0; i < DEPTH + 2; i++)
      push_cmd(KIND_ENQ, 32'd100 + i, 8'(i * 15), ~32'(i), $urandom);
    // one tick before the stamp: largest possible latency
    push_cmd(KIND_DEQ, 32'd99, 8'h00, '0, '0);
    push_cmd(KIND_DEQ, 32'd200, 8'h00, '0, '0);

    // random runs that push the fifo to full, drain it to empty, or mix
    t_ms     = 32'd1000;
    run_left = 0;
    shape    = MIXED_RUN;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (run_left == 0) begin
        shape    = run_shape_t'($urandom_range(0, 2));
        run_left = $urandom_range(5, 40);
      end
      run_left--;
      pick = $urandom_range(0, 99);
      if (pick < 3)      t_ms = $urandom;   // jump anywhere, backwards too
      else if (pick < 6) t_ms = 32'hffff_ffff - $urandom_range(0, 200);
      else               t_ms = t_ms + $urandom_range(0, 300);
      pick = $urandom_range(0, 9);
      case (shape)
        FILL_RUN:  kind = (pick < 8) ? KIND_ENQ : KIND_DEQ;
        DRAIN_RUN: kind = (pick < 8) ? KIND_DEQ : KIND_ENQ;
        default:   kind = (pick < 5) ? KIND_ENQ : KIND_DEQ;
      endcase
      push_cmd(kind, t_ms, 8'($urandom_range(0, 255)),
               ($urandom_range(0, 15) == 0) ? '1 : 32'($urandom),
               ($urandom_range(0, 15) == 0) ? '0 : 32'($urandom));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // wait until every command went in and every result came back
    while (pending_cmds.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    // a late extra result would still be flagged by the monitor
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d command transfers and %0d result transfers", in_transfers,
             out_transfers);
    $display("%0d enqueues stored, %0d dropped when full, %0d dequeues, %0d on empty,",
             push_cnt, drop_cnt, pop_cnt, empty_pops);
    $display("peak latency %0d ms", lat_peak);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
